[design/rsst_pkg.sv]
// Package with shared constants, codes and control types of the range-sum segment tree.
`timescale 1ns / 1ps

package rsst_pkg;

   // Tree geometry: leaves sit at nodes NUM_ELEMENTS .. 2*NUM_ELEMENTS-1.
   localparam int NUM_ELEMENTS = 1024;
   localparam int NODE_COUNT   = 2 * NUM_ELEMENTS;
   localparam int NODE_AW      = $clog2(NODE_COUNT);
   // Range bounds run one past the last node, so they need one more bit.
   localparam int BOUND_W      = NODE_AW + 1;

   // Transaction field widths.
   localparam int IDX_W  = 10;
   localparam int DATA_W = 32;

   // Width wide enough to compare an index against the element count.
   localparam int CMP_W = (IDX_W + 1 > BOUND_W) ? IDX_W + 1 : BOUND_W;

   // Command codes.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Status codes.
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_en;   // zero one node of the clearing pass
      logic load;       // capture a request and set up the walk
      logic leaf_wr;    // write the new leaf value
      logic up_step;    // read the sibling and climb one level
      logic total_rd;   // read the root for an unchanged total
      logic take_l;     // read node l and advance l
      logic take_r;     // step r back and read node r
      logic shift;      // move l and r up one level
      logic out_load;   // move the result into the output register
   } rsst_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_done;
      logic is_query;
      logic err;
      logic p_gt1;
      logic l_lt_r;
      logic l_odd;
      logic r_odd;
      logic out_free;
   } rsst_stat_type;

endpackage

[design/rsst_if.sv]
// Request and response channel interfaces of the range-sum segment tree.
`timescale 1ns / 1ps

interface rsst_req_if import rsst_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               cmd;
   logic [IDX_W-1:0]   index_low;
   logic [IDX_W-1:0]   index_high;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, cmd, index_low, index_high, value, input ready);
   modport sink   (input valid, cmd, index_low, index_high, value, output ready);
endinterface

interface rsst_rsp_if import rsst_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sum;
   logic                     status;

   modport source (output valid, sum, status, input ready);
   modport sink   (input valid, sum, status, output ready);
endinterface

[design/rsst_ctrl.sv]
// Controller state machine that sequences clearing, point writes and range queries.
`timescale 1ns / 1ps

module rsst_ctrl import rsst_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  rsst_stat_type stat,
   output rsst_cmd_type  cmd
);

   typedef enum logic [7:0] {
      ST_CLEAR    = 8'b0000_0001,
      ST_IDLE     = 8'b0000_0010,
      ST_DISPATCH = 8'b0000_0100,
      ST_WR_UP    = 8'b0000_1000,
      ST_Q_L      = 8'b0001_0000,
      ST_Q_R      = 8'b0010_0000,
      ST_FINISH   = 8'b0100_0000,
      ST_LOAD     = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (stat.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            priority if (stat.err && !stat.is_query) begin
               // A bad write still reports the unchanged total.
               cmd.total_rd = 1'b1;
               state_in     = ST_FINISH;
            end else if (stat.err) begin
               state_in = ST_FINISH;
            end else if (!stat.is_query) begin
               cmd.leaf_wr = 1'b1;
               state_in    = ST_WR_UP;
            end else begin
               state_in = ST_Q_L;
            end
         end
         ST_WR_UP: begin
            if (stat.p_gt1) begin
               cmd.up_step = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_Q_L: begin
            priority if (!stat.l_lt_r) begin
               state_in = ST_FINISH;
            end else if (stat.l_odd) begin
               cmd.take_l = 1'b1;
               state_in   = ST_Q_R;
            end else if (stat.r_odd) begin
               cmd.take_r = 1'b1;
               cmd.shift  = 1'b1;
            end else begin
               cmd.shift = 1'b1;
            end
         end
         ST_Q_R: begin
            cmd.take_r = stat.r_odd;
            cmd.shift  = 1'b1;
            state_in   = ST_Q_L;
         end
         ST_FINISH: begin
            // For a rejected write the root read is added into the accumulator here.
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

[design/rsst_datapath.sv]
// Datapath with the node-sum memory, walk registers, accumulator and output register.
`timescale 1ns / 1ps

module rsst_datapath import rsst_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  rsst_cmd_type             cmd,
   output rsst_stat_type            stat,
   input  logic                     req_cmd,
   input  logic [IDX_W-1:0]         req_index_low,
   input  logic [IDX_W-1:0]         req_index_high,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_sum,
   output logic                     rsp_status
);

   logic [DATA_W-1:0]  mem [NODE_COUNT];

   logic [NODE_AW-1:0] clr_cnt_ff;
   logic               cmd_ff;
   logic               err_ff;
   logic [DATA_W-1:0]  value_ff;
   logic [NODE_AW-1:0] p_ff;
   logic [NODE_AW-1:0] par_addr_ff;
   logic [BOUND_W-1:0] l_ff;
   logic [BOUND_W-1:0] r_ff;
   logic [DATA_W-1:0]  acc_ff;
   logic [DATA_W-1:0]  acc_in;
   logic [DATA_W-1:0]  rd_data_ff;
   logic               add_pend_ff;
   logic               up_pend_ff;
   logic               out_valid_ff;
   logic [DATA_W-1:0]  out_sum_ff;
   logic               out_status_ff;

   logic [CMP_W-1:0]   lo_ext;
   logic [CMP_W-1:0]   hi_ext;
   logic               req_err;
   logic [BOUND_W-1:0] l_mid;
   logic [BOUND_W-1:0] r_mid;
   logic [BOUND_W-1:0] r_dec;
   logic [DATA_W-1:0]  sum_now;
   logic               rd_en;
   logic [NODE_AW-1:0] rd_addr;
   logic               wr_en;
   logic [NODE_AW-1:0] wr_addr;
   logic [DATA_W-1:0]  wr_data;

   // Bounds check of the incoming transaction.
   assign lo_ext = CMP_W'(req_index_low);
   assign hi_ext = CMP_W'(req_index_high);
   always_comb begin
      if (req_cmd == CMD_WRITE) begin
         req_err = (lo_ext >= CMP_W'(NUM_ELEMENTS));
      end else begin
         req_err = (hi_ext >= CMP_W'(NUM_ELEMENTS)) || (lo_ext > hi_ext);
      end
   end

   // Clearing pass counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_cnt_ff <= clr_cnt_ff + NODE_AW'(1);
      end
   end

   // Captured transaction fields.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_cmd;
         err_ff   <= req_err;
         value_ff <= DATA_W'(req_value);
      end
   end

   // Leaf path pointer for writes.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p_ff <= NODE_AW'(lo_ext + CMP_W'(NUM_ELEMENTS));
      end else if (cmd.up_step) begin
         p_ff <= p_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.up_step) begin
         par_addr_ff <= p_ff >> 1;
      end
   end

   // Query bounds: l is inclusive, r is exclusive.
   assign r_dec = r_ff - BOUND_W'(1);
   assign l_mid = cmd.take_l ? (l_ff + BOUND_W'(1)) : l_ff;
   assign r_mid = cmd.take_r ? r_dec : r_ff;

   always_ff @(posedge clock) begin
      priority if (cmd.load) begin
         l_ff <= BOUND_W'(lo_ext + CMP_W'(NUM_ELEMENTS));
         r_ff <= BOUND_W'(hi_ext + CMP_W'(NUM_ELEMENTS) + CMP_W'(1));
      end else if (cmd.shift) begin
         l_ff <= l_mid >> 1;
         r_ff <= r_mid >> 1;
      end else begin
         l_ff <= l_mid;
         r_ff <= r_mid;
      end
   end

   // Memory read port address select.
   assign rd_en = cmd.up_step | cmd.total_rd | cmd.take_l | cmd.take_r;
   always_comb begin
      priority if (cmd.up_step) begin
         rd_addr = {p_ff[NODE_AW-1:1], ~p_ff[0]};
      end else if (cmd.total_rd) begin
         rd_addr = NODE_AW'(1);
      end else if (cmd.take_l) begin
         rd_addr = l_ff[NODE_AW-1:0];
      end else begin
         rd_addr = r_dec[NODE_AW-1:0];
      end
   end

   // Registered memory read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Pending flags for data returning from the read port.
   always_ff @(posedge clock) begin
      if (reset) begin
         add_pend_ff <= 1'b0;
         up_pend_ff  <= 1'b0;
      end else begin
         add_pend_ff <= rd_en;
         up_pend_ff  <= cmd.up_step;
      end
   end

   assign sum_now = acc_ff + rd_data_ff;

   // Accumulator: running subtree sum for writes, range sum for queries.
   always_comb begin
      priority if (cmd.load) begin
         acc_in = '0;
      end else if (cmd.leaf_wr) begin
         acc_in = value_ff;
      end else if (add_pend_ff) begin
         acc_in = sum_now;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Memory write port select.
   always_comb begin
      wr_en   = 1'b1;
      priority if (cmd.clear_en) begin
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else if (cmd.leaf_wr) begin
         wr_addr = p_ff;
         wr_data = value_ff;
      end else if (up_pend_ff) begin
         wr_addr = par_addr_ff;
         wr_data = sum_now;
      end else begin
         wr_en   = 1'b0;
         wr_addr = par_addr_ff;
         wr_data = sum_now;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Output register holds one result until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_sum_ff    <= acc_ff;
         out_status_ff <= err_ff ? STATUS_ERR : STATUS_OK;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sum    = $signed(out_sum_ff);
   assign rsp_status = out_status_ff;

   // Status back to the controller.
   always_comb begin
      stat.clear_done = (clr_cnt_ff == NODE_AW'(NODE_COUNT - 1));
      stat.is_query   = (cmd_ff == CMD_QUERY);
      stat.err        = err_ff;
      stat.p_gt1      = (p_ff > NODE_AW'(1));
      stat.l_lt_r     = (l_ff < r_ff);
      stat.l_odd      = l_ff[0];
      stat.r_odd      = r_ff[0];
      stat.out_free   = !out_valid_ff || rsp_ready;
   end

endmodule

[design/range_sum_segment_tree_unit.sv]
// Sequence: a write stores its leaf, then climbs to the root and rewrites each parent;
// a query moves its bounds l and r up the tree and adds in each node that it reads.
// Throughput: one transaction at a time. The walk reads at most one node per cycle from the
// single read port, and the next request can be taken the cycle after the response is loaded.
// Rejected transactions skip the walk and go from dispatch straight to finish and load.
// Reset: synchronous; afterwards a clearing pass zeroes all 2*NUM_ELEMENTS nodes, one per
// cycle, before the first request is accepted.
`timescale 1ns / 1ps

module range_sum_segment_tree_unit import rsst_pkg::*; (
   input  logic clock,
   input  logic reset,
   rsst_req_if.sink   req_chan,
   rsst_rsp_if.source rsp_chan
);

   rsst_cmd_type  cmd;
   rsst_stat_type stat;

   // Sequencing of clearing, updates and queries.
   rsst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Node memory, walk registers and result stage.
   rsst_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_cmd        (req_chan.cmd),
      .req_index_low  (req_chan.index_low),
      .req_index_high (req_chan.index_high),
      .req_value      (req_chan.value),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_sum        (rsp_chan.sum),
      .rsp_status     (rsp_chan.status)
   );

endmodule

[design/rsst_checker.sv]
// Port-level assertions for the range-sum segment tree, bound to the top level.
`timescale 1ns / 1ps

module rsst_checker import rsst_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_sum,
   input logic                     rsp_status
);

   // A stalled response keeps its valid.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_sum) && $stable(rsp_status))
      else $error("response payload changed while stalled");

   // The clearing pass keeps requests out right after reset.
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request ready during clearing pass");

   // Only one transaction is in the tree at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted while one is in progress");

endmodule

bind range_sum_segment_tree_unit rsst_checker u_rsst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_sum    (rsp_chan.sum),
   .rsp_status (rsp_chan.status)
);
